// ----- design/gps_fix_gate_kalman_smoother_assert.svh -----
// assertion macros shared by the checker
`ifndef GPS_FIX_GATE_KALMAN_SMOOTHER_ASSERT_SVH
`define GPS_FIX_GATE_KALMAN_SMOOTHER_ASSERT_SVH

// checked only out of reset
`define GFKS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define GFKS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/gfks_pkg.sv -----
`timescale 1ns / 1ps
package gfks_pkg;
  localparam int CoordW = 48;
  localparam int VarW = 64;
  localparam int NoiseW = 63;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;
  localparam logic [VarW-1:0] VarInit = 64'hF424_0000_0000_0000;

  localparam logic [CfgIdxW-1:0] RegMinSats = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinFix = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRecover = 3'd2;
  localparam logic [CfgIdxW-1:0] RegProcNoise = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMeasNoise = 3'd4;

  typedef enum logic [1:0] {
    L_IDLE,
    L_DIV,
    L_MUL,
    L_DONE
  } lane_state_t;

  typedef struct packed {
    logic start;
    logic filt_reset;
    logic signed [CoordW-1:0] z;
  } lane_cmd_t;

  typedef struct packed {
    logic done;
  } lane_stat_t;
endpackage

// ----- design/gfks_lane.sv -----
`timescale 1ns / 1ps
module gfks_lane (
  input  logic clk,
  input  logic rst_n,
  input  gfks_pkg::lane_cmd_t cmd,
  input  logic ack,
  input  logic [gfks_pkg::NoiseW-1:0] process_noise,
  input  logic [gfks_pkg::NoiseW-1:0] measure_noise,
  output gfks_pkg::lane_stat_t stat,
  output logic signed [gfks_pkg::CoordW-1:0] est
);
  import gfks_pkg::*;

  lane_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic primed_r;
  logic signed [CoordW-1:0] est_r;
  logic [VarW-1:0] var_r;
  logic [VarW-1:0] d_r, rem_r;
  logic [31:0] q_r;
  logic kone_r, neg_r, prep_r;
  logic [CoordW-1:0] mag_r;
  logic [63:0] prod_r, t_r;
  logic [31:0] mul_a, mul_b, g_lo;
  logic [64:0] var_sum;
  logic [VarW-1:0] var_sat, rem_sh, rnd_sum;
  logic signed [CoordW:0] diff;
  logic [VarW-1:0] p_w, r_w, d_w;

  assign var_sum = {1'b0, var_r} + {2'b00, process_noise};
  assign var_sat = var_sum[64] ? {VarW{1'b1}} : var_sum[VarW-1:0];
  assign p_w = {2'b00, var_r[VarW-1:2]};
  assign r_w = {3'b000, measure_noise[NoiseW-1:2]};
  assign d_w = p_w + r_w;
  assign rem_sh = {rem_r[VarW-2:0], 1'b0};
  assign diff = {cmd.z[CoordW-1], cmd.z} - {est_r[CoordW-1], est_r};
  assign g_lo = 32'd0 - q_r;
  assign rnd_sum = t_r + ((prod_r + 64'h8000_0000) >> 32);

  // step 0,1: magnitude times gain; step 2,3: variance times one minus gain
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: begin mul_a = {16'h0, mag_r[CoordW-1:32]}; mul_b = q_r; end
      2'd1: begin mul_a = mag_r[31:0]; mul_b = q_r; end
      2'd2: begin mul_a = var_r[63:32]; mul_b = g_lo; end
      default: begin mul_a = var_r[31:0]; mul_b = g_lo; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      L_IDLE: if (cmd.start) begin
        state_nxt = (primed_r && !cmd.filt_reset) ? L_DIV : L_DONE;
        cnt_nxt = '0;
      end
      L_DIV: if (!prep_r) begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = L_MUL;
          cnt_nxt = '0;
        end
      end
      L_MUL: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd4) state_nxt = L_DONE;
      end
      default: if (ack) state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      cnt_r <= '0;
      primed_r <= 1'b0;
      est_r <= '0;
      var_r <= VarInit;
      prep_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      // a reset that comes with a start primes the lane below
      if (cmd.filt_reset) begin
        if (!cmd.start) primed_r <= 1'b0;
        var_r <= VarInit;
      end
      unique case (state_r)
        L_IDLE: if (cmd.start) begin
          if (primed_r && !cmd.filt_reset) begin
            var_r <= var_sat;
            neg_r <= diff[CoordW];
            mag_r <= diff[CoordW] ? CoordW'(-diff) : diff[CoordW-1:0];
            prep_r <= 1'b1;
          end else begin
            est_r <= cmd.z;
            primed_r <= 1'b1;
          end
        end
        L_DIV: begin
          if (prep_r) begin
            prep_r <= 1'b0;
            d_r <= d_w;
            rem_r <= p_w;
            q_r <= '0;
            kone_r <= (r_w == '0) || (d_w == '0);
          end else if (rem_sh >= d_r) begin
            rem_r <= rem_sh - d_r;
            q_r <= {q_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            q_r <= {q_r[30:0], 1'b0};
          end
        end
        L_MUL: begin
          prod_r <= mul_a * mul_b;
          if (cnt_r == 5'd1 || cnt_r == 5'd3) t_r <= prod_r;
          if (cnt_r == 5'd2) begin
            if (kone_r)
              est_r <= neg_r ? est_r - $signed(mag_r) : est_r + $signed(mag_r);
            else if (neg_r)
              est_r <= est_r - $signed(rnd_sum[CoordW-1:0]);
            else
              est_r <= est_r + $signed(rnd_sum[CoordW-1:0]);
          end
          if (cnt_r == 5'd4) begin
            // gain one leaves no variance, gain zero keeps it
            if (kone_r) var_r <= '0;
            else if (q_r != '0) var_r <= rnd_sum;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.done = (state_r == L_DONE);
  assign est = est_r;
endmodule

// ----- design/gps_fix_gate_kalman_smoother.sv -----
`timescale 1ns / 1ps
// GPS fix gate with three scalar Kalman smoothers. Each accepted fix is gated
// at once; fixes that do not produce a result leave the input ready. While
// active a fix runs one lane per axis in parallel, each with a restoring
// divider for the 32-bit gain and five steps on its own 32x32 multiplier. A
// finished result waits in an output register while the next request is
// taken. Configuration writes are always ready.
module gps_fix_gate_kalman_smoother (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [gfks_pkg::CoordW-1:0] in_latitude_in,
  input  logic signed [gfks_pkg::CoordW-1:0] in_longitude_in,
  input  logic signed [gfks_pkg::CoordW-1:0] in_altitude_in,
  input  logic signed [7:0] in_fix_status,
  input  logic [15:0] in_satellite_count,
  input  logic in_coordinate_nan,
  input  logic in_lat_cov_negative,
  input  logic in_lon_cov_negative,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [gfks_pkg::CoordW-1:0] out_latitude_out,
  output logic signed [gfks_pkg::CoordW-1:0] out_longitude_out,
  output logic signed [gfks_pkg::CoordW-1:0] out_altitude_out,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [gfks_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [gfks_pkg::CfgDataW-1:0] cfg_data
);
  import gfks_pkg::*;

  logic [15:0] sat_floor_r, recover_r, run_r, run_inc;
  logic signed [7:0] min_fix_r;
  logic [NoiseW-1:0] q_noise_r, r_noise_r;
  logic active_r, busy_r, out_valid_r;
  logic accept, bad, good, activate, start, freset, collect, all_done;
  logic signed [CoordW-1:0] lat_r, lon_r, alt_r;
  lane_cmd_t cmd0, cmd1, cmd2;
  lane_stat_t st0, st1, st2;
  logic signed [CoordW-1:0] est0, est1, est2;

  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;
  assign in_ready = !busy_r;
  assign bad = in_coordinate_nan || in_lat_cov_negative || in_lon_cov_negative;
  assign good = !bad && (in_fix_status >= min_fix_r) && (in_satellite_count >= sat_floor_r);
  assign run_inc = (run_r == 16'hFFFF) ? run_r : run_r + 16'd1;
  assign activate = good && !active_r && (run_inc >= recover_r);
  assign start = accept && good && (active_r || activate);
  assign freset = accept && (!good || activate);
  assign all_done = st0.done && st1.done && st2.done;
  assign collect = all_done && (!out_valid_r || out_ready);

  assign cmd0 = '{start: start, filt_reset: freset, z: in_latitude_in};
  assign cmd1 = '{start: start, filt_reset: freset, z: in_longitude_in};
  assign cmd2 = '{start: start, filt_reset: freset, z: in_altitude_in};

  gfks_lane u_lat (.clk, .rst_n, .cmd(cmd0), .ack(collect), .process_noise(q_noise_r),
    .measure_noise(r_noise_r), .stat(st0), .est(est0));
  gfks_lane u_lon (.clk, .rst_n, .cmd(cmd1), .ack(collect), .process_noise(q_noise_r),
    .measure_noise(r_noise_r), .stat(st1), .est(est1));
  gfks_lane u_alt (.clk, .rst_n, .cmd(cmd2), .ack(collect), .process_noise(q_noise_r),
    .measure_noise(r_noise_r), .stat(st2), .est(est2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_floor_r <= 16'd15;
      min_fix_r <= 8'sd2;
      recover_r <= 16'd100;
      q_noise_r <= 63'd17592186;
      r_noise_r <= 63'd17592186044;
      active_r <= 1'b0;
      run_r <= '0;
      busy_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          RegMinSats: sat_floor_r <= cfg_data[15:0];
          RegMinFix: min_fix_r <= $signed(cfg_data[7:0]);
          RegRecover: recover_r <= cfg_data[15:0];
          RegProcNoise: q_noise_r <= cfg_data[NoiseW-1:0];
          RegMeasNoise: r_noise_r <= cfg_data[NoiseW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (!good) begin
          active_r <= 1'b0;
          run_r <= '0;
        end else begin
          run_r <= run_inc;
          if (activate) active_r <= 1'b1;
        end
      end
      if (start) busy_r <= 1'b1;
      else if (collect) busy_r <= 1'b0;
      if (collect) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // merge stage: lanes finish together, a register per axis holds the result
  always_ff @(posedge clk) begin
    if (collect) begin
      lat_r <= est0;
      lon_r <= est1;
      alt_r <= est2;
    end
  end

  assign out_valid = out_valid_r;
  assign out_latitude_out = lat_r;
  assign out_longitude_out = lon_r;
  assign out_altitude_out = alt_r;
endmodule

// ----- design/gfks_checker.sv -----
`timescale 1ns / 1ps
`include "gps_fix_gate_kalman_smoother_assert.svh"
module gfks_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready,
  input logic [gfks_pkg::CoordW-1:0] out_latitude_out
);
  `GFKS_ASSERT_ALWAYS(a_rst_no_out, !rst_n |=> !out_valid, "result after reset")
  `GFKS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")
  `GFKS_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_latitude_out),
    "result changed while stalled")
  `GFKS_ASSERT(a_cfg_ready, cfg_ready, "config port not ready")
endmodule

bind gps_fix_gate_kalman_smoother gfks_checker u_chk (.clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_ready(out_ready), .cfg_ready(cfg_ready),
  .out_latitude_out(out_latitude_out));
